@@ rtl/core/sdfp_pkg.sv @@
`timescale 1ns / 1ps
package sdfp_pkg;

  localparam logic [7:0]  TAG_RESET = 8'd97;  // 'a'
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [7:0]  CH_NINE   = 8'h39;
  localparam logic [7:0]  CH_COMMA  = 8'h2c;
  localparam logic [7:0]  CH_MINUS  = 8'h2d;
  localparam logic [7:0]  CH_STAR   = 8'h2a;
  localparam logic [31:0] ACC_MAX   = 32'h7fff_ffff;
  localparam logic [2:0]  FIELD_MAX = 3'd7;
  localparam logic [2:0]  FIELD_LAST_STORED = 3'd3;
  localparam logic [1:0]  MINUS_MAX = 2'd3;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [0:0] {
    REG_CLIENT_TAG = 1'b0
  } reg_idx_e;

  typedef enum logic [2:0] {
    EV_STORED = 3'd0,
    EV_DONE   = 3'd1,
    EV_MINUS  = 3'd2,
    EV_DATA   = 3'd3,
    EV_CLIENT = 3'd4
  } event_e;

  typedef enum logic [3:0] {
    MODE_HEADER = 4'b0001,
    MODE_SKIP   = 4'b0010,
    MODE_SCAN   = 4'b0100,
    MODE_IDLE   = 4'b1000
  } frame_mode_e;

  typedef struct packed {
    event_e      ev;
    logic [31:0] first;
    logic [31:0] second;
    logic [31:0] third;
  } result_t;

endpackage

@@ rtl/core/sdfp_regs.sv @@
`timescale 1ns / 1ps
module sdfp_regs import sdfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [7:0]        client_tag_o
);

  logic [7:0] tag_q, tag_d;
  reg_idx_e   idx;
  logic       in_range;

  // registers sit on 4-byte strides; bit 2 selects the register
  assign idx      = reg_idx_e'(paddr[2]);
  assign in_range = (idx == REG_CLIENT_TAG);
  assign pready   = 1'b1;

  always_comb begin
    tag_d = tag_q;
    if (psel && penable && pwrite && in_range) begin
      tag_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= TAG_RESET;
    end else begin
      tag_q <= tag_d;
    end
  end

  always_comb begin
    case (idx)
      REG_CLIENT_TAG: prdata = {{(APB_DW-8){1'b0}}, tag_q};
      default:        prdata = '0;
    endcase
  end

  assign client_tag_o = tag_q;

endmodule

@@ rtl/core/sdfp_parse.sv @@
`timescale 1ns / 1ps
module sdfp_parse import sdfp_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic [7:0] client_tag_i,
  output logic       emit_o,
  output result_t    result_o
);

  localparam int unsigned PW = $clog2(FRAME_BYTES + 1);

  logic [31:0] first_q, first_d, second_q, second_d, third_q, third_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  fcnt_q, fcnt_d;
  logic [1:0]  mcnt_q, mcnt_d;
  logic [PW-1:0] pos_q, pos_d;
  frame_mode_e mode_q, mode_d;

  logic        is_digit;
  logic [35:0] acc_next;
  logic [31:0] signed_val;
  event_e      ev;
  logic        emit;

  assign is_digit = (byte_i inside {[CH_ZERO:CH_NINE]});
  // acc*10 + digit as shift-adds; acc never exceeds 31 bits
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                  + {28'd0, byte_i - CH_ZERO};
  assign signed_val = (mcnt_q == 2'd1) ? (32'd0 - acc_q) : acc_q;

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    third_d  = third_q;
    acc_d    = acc_q;
    fcnt_d   = fcnt_q;
    mcnt_d   = mcnt_q;
    pos_d    = pos_q;
    mode_d   = mode_q;
    emit     = 1'b0;
    ev       = EV_STORED;

    if (pos_q < PW'(FRAME_BYTES)) begin
      pos_d = pos_q + PW'(1);
      case (mode_q)
        MODE_HEADER: begin
          if (byte_i == client_tag_i) begin
            mode_d = MODE_SKIP;
          end else begin
            mode_d = MODE_IDLE;
            emit   = 1'b1;
            ev     = EV_CLIENT;
          end
        end
        MODE_SKIP: begin
          mode_d = MODE_SCAN;
        end
        MODE_SCAN: begin
          if (is_digit) begin
            acc_d = (acc_next > {4'd0, ACC_MAX}) ? ACC_MAX : acc_next[31:0];
          end else if (byte_i == CH_MINUS) begin
            if (mcnt_q != MINUS_MAX) mcnt_d = mcnt_q + 2'd1;
          end else if (byte_i == CH_COMMA) begin
            if (fcnt_q != FIELD_MAX) fcnt_d = fcnt_q + 3'd1;
            if (mcnt_q >= 2'd2) begin
              emit = 1'b1;
              ev   = EV_MINUS;
            end else if (fcnt_d <= FIELD_LAST_STORED) begin
              case (fcnt_d)
                3'd1:    first_d  = signed_val;
                3'd2:    second_d = signed_val;
                default: third_d  = signed_val;
              endcase
              acc_d  = '0;
              mcnt_d = '0;
              emit   = 1'b1;
              ev     = EV_STORED;
            end
          end else if (byte_i == CH_STAR) begin
            acc_d  = '0;
            fcnt_d = '0;
            mcnt_d = '0;
            mode_d = MODE_IDLE;
            emit   = 1'b1;
            ev     = EV_DONE;
          end else begin
            mode_d = MODE_IDLE;
            emit   = 1'b1;
            ev     = EV_DATA;
          end
        end
        default: ;
      endcase
    end

    if (last_i) begin
      acc_d  = '0;
      fcnt_d = '0;
      mcnt_d = '0;
      pos_d  = '0;
      mode_d = MODE_HEADER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      third_q  <= '0;
      acc_q    <= '0;
      fcnt_q   <= '0;
      mcnt_q   <= '0;
      pos_q    <= '0;
      mode_q   <= MODE_HEADER;
    end else if (fire_i) begin
      first_q  <= first_d;
      second_q <= second_d;
      third_q  <= third_d;
      acc_q    <= acc_d;
      fcnt_q   <= fcnt_d;
      mcnt_q   <= mcnt_d;
      pos_q    <= pos_d;
      mode_q   <= mode_d;
    end
  end

  assign emit_o          = fire_i && emit;
  assign result_o.ev     = ev;
  assign result_o.first  = first_d;
  assign result_o.second = second_d;
  assign result_o.third  = third_d;

endmodule

@@ rtl/core/sdfp_out_reg.sv @@
`timescale 1ns / 1ps
module sdfp_out_reg import sdfp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    stall_i,
  output logic    valid_o,
  output logic    free_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // free when empty or when the held transaction leaves this cycle
  assign free_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

@@ rtl/core/signed_decimal_field_parser.sv @@
`timescale 1ns / 1ps
// Path: a byte accepted into the input register is parsed when it fires, and its
// result is loaded into the output register, from which the transaction completes.
// Throughput: one byte per cycle; the input register, the parse logic and the
// output register advance together whenever the output register is free.
// Reset (rst_ni, async, active low): stores, counters and frame state cleared,
// client_tag back to 'a', both pipeline registers empty.
module signed_decimal_field_parser import sdfp_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        byte_value_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        event_code_o,
  output logic [31:0]       first_value_o,
  output logic [31:0]       second_value_o,
  output logic [31:0]       third_value_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       advance, fire, accept, emit;
  logic [7:0] client_tag;
  result_t    res_d, res_q;

  sdfp_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .client_tag_o (client_tag)
  );

  // input register moves when the output side can take a result
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= byte_value_i;
      last_q <= last_i;
    end
  end

  sdfp_parse #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parse (
    .clk_i,
    .rst_ni,
    .fire_i       (fire),
    .byte_i       (byte_q),
    .last_i       (last_q),
    .client_tag_i (client_tag),
    .emit_o       (emit),
    .result_o     (res_d)
  );

  sdfp_out_reg u_out (
    .clk_i,
    .rst_ni,
    .load_i   (emit),
    .result_i (res_d),
    .stall_i  (out_stall_i),
    .valid_o  (out_valid_o),
    .free_o   (advance),
    .result_o (res_q)
  );

  assign event_code_o   = res_q.ev;
  assign first_value_o  = res_q.first;
  assign second_value_o = res_q.second;
  assign third_value_o  = res_q.third;

endmodule
